[hw/rtl/pps_pkg.sv]
package pps_pkg;

  // width of every coordinate field on the channels
  localparam int FIELD_BITS = 12;

  // memory read address select
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_I,
    RD_J,
    RD_JNEXT,
    RD_E
  } rd_sel_t;

  // memory write select outside of loading
  typedef enum logic [2:0] {
    WR_NONE,
    WR_PK_RDATA,
    WR_ZERO_PIV,
    WR_K_IVAL,
    WR_I_BEST
  } wr_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    clear;
    logic    i_init;
    logic    i_inc;
    logic    row_init;
    logic    row_load;
    logic    mul;
    logic    dec;
    logic    e_init;
    logic    e_inc;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic j_last;
    logic row_go;
    logic row_next;
    logic e_last;
  } status_t;

endpackage

[hw/rtl/pps_in_if.sv]
interface pps_in_if;
  logic                           valid;
  logic                           ready;
  logic [pps_pkg::FIELD_BITS-1:0] point_x;
  logic [pps_pkg::FIELD_BITS-1:0] point_y;
  logic                           last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

[hw/rtl/pps_out_if.sv]
interface pps_out_if;
  logic                           valid;
  logic                           ready;
  logic [pps_pkg::FIELD_BITS-1:0] out_x;
  logic [pps_pkg::FIELD_BITS-1:0] out_y;
  logic                           out_last;
  logic                           dropped_points;

  modport source (output valid, output out_x, output out_y, output out_last,
                  output dropped_points, input ready);
  modport sink (input valid, input out_x, input out_y, input out_last,
                input dropped_points, output ready);
endinterface

[hw/rtl/polar_angle_point_sort_top.sv]
// channel   dir  handshake     payload
// pt_in     in   valid/ready   point_x, point_y, last_point
// pt_out    out  valid/ready   out_x, out_y, out_last, dropped_points
//
// loading takes one point per cycle while in_ready is high; the set is then selection
// sorted by angle, each compare an S_MUL then S_DEC step on the single memory read port
// results are read in S_OUT_RD and held in S_SHOW until taken; no new point is
// taken from the last point of a set until its final result is taken
// synchronous reset clears the control state, point count and overflow flag;
// the point memory needs no clearing pass
module polar_angle_point_sort_top #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12
) (
  input  logic             clk,
  input  logic             rst,
  pps_in_if.sink           pt_in,
  pps_out_if.source        pt_out
);

  pps_pkg::cmd_t    cmd;
  pps_pkg::status_t status;

  // sequencer
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pt_in.valid),
    .in_last   (pt_in.last_point),
    .in_ready  (pt_in.ready),
    .out_valid (pt_out.valid),
    .out_ready (pt_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // point memory and compare datapath
  pps_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .point_x        (pt_in.point_x),
    .point_y        (pt_in.point_y),
    .status         (status),
    .out_x          (pt_out.out_x),
    .out_y          (pt_out.out_y),
    .out_last       (pt_out.out_last),
    .dropped_points (pt_out.dropped_points)
  );

endmodule

[hw/rtl/pps_datapath.sv]
module pps_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pps_pkg::cmd_t                  cmd,
  input  logic [pps_pkg::FIELD_BITS-1:0] point_x,
  input  logic [pps_pkg::FIELD_BITS-1:0] point_y,
  output pps_pkg::status_t               status,
  output logic [pps_pkg::FIELD_BITS-1:0] out_x,
  output logic [pps_pkg::FIELD_BITS-1:0] out_y,
  output logic                           out_last,
  output logic                           dropped_points
);

  localparam int FB   = pps_pkg::FIELD_BITS;
  localparam int CW   = (COORD_BITS < FB) ? COORD_BITS : FB;
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int PW   = 2 * (CW + 1);

  typedef struct packed {
    logic [CW-1:0] y;
    logic [CW-1:0] x;
  } pt_t;

  // point memory, one write and one registered read per cycle
  pt_t mem [MAX_POINTS];
  pt_t rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  pt_t           wdata;
  logic          we;

  logic [CNTW-1:0] count;
  logic            overflow;
  pt_t             piv;
  logic [AW-1:0]   pk;
  logic [AW-1:0]   i;
  logic [AW-1:0]   j;
  logic [AW-1:0]   k;
  logic [AW-1:0]   e;
  pt_t             ival;
  pt_t             best;
  pt_t             cand;
  logic [PW:0]     best_dist;
  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;
  logic [PW-1:0]   sx;
  logic [PW-1:0]   sy;

  pt_t             newp;
  logic            store_ok;
  logic            piv_upd;
  logic signed [CW:0]   ax;
  logic signed [CW:0]   ay;
  logic signed [CW:0]   bx;
  logic signed [CW:0]   by;
  logic signed [PW-1:0] m_p1;
  logic signed [PW-1:0] m_p2;
  logic signed [PW-1:0] qx;
  logic signed [PW-1:0] qy;
  logic [PW:0]     cand_dist;
  logic            take;
  logic [CNTW:0]   n_ext;

  // incoming point and pivot tracking
  assign newp.x   = point_x[CW-1:0];
  assign newp.y   = point_y[CW-1:0];
  assign store_ok = (count < CNTW'(MAX_POINTS));
  assign piv_upd  = (count == '0) || (newp.y < piv.y) ||
                    ((newp.y == piv.y) && (newp.x < piv.x));

  // differences against pivot and current best
  assign ax   = $signed({1'b0, piv.x}) - $signed({1'b0, rdata.x});
  assign ay   = $signed({1'b0, piv.y}) - $signed({1'b0, rdata.y});
  assign bx   = $signed({1'b0, best.x}) - $signed({1'b0, rdata.x});
  assign by   = $signed({1'b0, best.y}) - $signed({1'b0, rdata.y});
  assign m_p1 = ax * by;
  assign m_p2 = bx * ay;
  assign qx   = ax * ax;
  assign qy   = ay * ay;

  // angle test, nearer first on equal angle
  assign cand_dist = {1'b0, sx} + {1'b0, sy};
  assign take      = (p1 > p2) || ((p1 == p2) && (cand_dist < best_dist));

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      pps_pkg::RD_ZERO:  raddr = '0;
      pps_pkg::RD_I:     raddr = i;
      pps_pkg::RD_J:     raddr = j;
      pps_pkg::RD_JNEXT: raddr = j + AW'(1);
      pps_pkg::RD_E:     raddr = e;
      default:           raddr = e;
    endcase
  end

  // write select
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    if (cmd.load) begin
      we    = store_ok;
      waddr = count[AW-1:0];
      wdata = newp;
    end else begin
      case (cmd.wr_sel)
        pps_pkg::WR_PK_RDATA: begin
          we    = 1'b1;
          waddr = pk;
          wdata = rdata;
        end
        pps_pkg::WR_ZERO_PIV: begin
          we    = 1'b1;
          waddr = '0;
          wdata = piv;
        end
        pps_pkg::WR_K_IVAL: begin
          we    = 1'b1;
          waddr = k;
          wdata = ival;
        end
        pps_pkg::WR_I_BEST: begin
          we    = 1'b1;
          waddr = i;
          wdata = best;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.clear) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.load) begin
      if (store_ok) begin
        count <= count + CNTW'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // pivot, loop indexes and compare registers
  always_ff @(posedge clk) begin
    if (cmd.load && store_ok && piv_upd) begin
      piv <= newp;
      pk  <= count[AW-1:0];
    end
    if (cmd.i_init) begin
      i <= AW'(1);
    end else if (cmd.i_inc) begin
      i <= i + AW'(1);
    end
    if (cmd.row_init) begin
      j <= i + AW'(1);
      k <= i;
    end
    if (cmd.row_load) begin
      ival      <= rdata;
      best      <= rdata;
      best_dist <= {1'b0, $unsigned(qx)} + {1'b0, $unsigned(qy)};
    end
    if (cmd.mul) begin
      cand <= rdata;
      p1   <= m_p1;
      p2   <= m_p2;
      sx   <= $unsigned(qx);
      sy   <= $unsigned(qy);
    end
    if (cmd.dec) begin
      if (take) begin
        best      <= cand;
        best_dist <= cand_dist;
        k         <= j;
      end
      j <= j + AW'(1);
    end
    if (cmd.e_init) begin
      e <= '0;
    end else if (cmd.e_inc) begin
      e <= e + AW'(1);
    end
  end

  // loop end flags
  assign n_ext           = (CNTW + 1)'(count);
  assign status.j_last   = ((CNTW + 1)'(j) + (CNTW + 1)'(1)) == n_ext;
  assign status.row_go   = ((CNTW + 1)'(i) + (CNTW + 1)'(1)) < n_ext;
  assign status.row_next = ((CNTW + 1)'(i) + (CNTW + 1)'(2)) < n_ext;
  assign status.e_last   = ((CNTW + 1)'(e) + (CNTW + 1)'(1)) == n_ext;

  // result payload straight from the read register
  assign out_x          = FB'(rdata.x);
  assign out_y          = FB'(rdata.y);
  assign out_last       = status.e_last;
  assign dropped_points = overflow;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_best_in_row: assert property (@(posedge clk) disable iff (rst)
    cmd.dec |-> ((k >= i) && (k < j)))
    else $error("best index outside current row");
`endif

endmodule

[hw/rtl/pps_ctrl.sv]
module pps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pps_pkg::status_t status,
  output pps_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PIV_RD,
    S_PIV_WR0,
    S_PIV_WR1,
    S_ROW_RD,
    S_ROW_LD,
    S_MUL,
    S_DEC,
    S_SWAP1,
    S_SWAP2,
    S_OUT_RD,
    S_SHOW
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_take;
  logic   out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = pps_pkg::RD_E;
    cmd.wr_sel = pps_pkg::WR_NONE;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = S_PIV_RD;
          end
        end
      end
      S_PIV_RD: begin
        cmd.rd_sel = pps_pkg::RD_ZERO;
        state_next = S_PIV_WR0;
      end
      S_PIV_WR0: begin
        cmd.wr_sel = pps_pkg::WR_PK_RDATA;
        cmd.i_init = 1'b1;
        state_next = S_PIV_WR1;
      end
      S_PIV_WR1: begin
        cmd.wr_sel = pps_pkg::WR_ZERO_PIV;
        cmd.e_init = 1'b1;
        state_next = status.row_go ? S_ROW_RD : S_OUT_RD;
      end
      S_ROW_RD: begin
        cmd.rd_sel   = pps_pkg::RD_I;
        cmd.row_init = 1'b1;
        state_next   = S_ROW_LD;
      end
      S_ROW_LD: begin
        cmd.row_load = 1'b1;
        cmd.rd_sel   = pps_pkg::RD_J;
        state_next   = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        if (status.j_last) begin
          state_next = S_SWAP1;
        end else begin
          cmd.rd_sel = pps_pkg::RD_JNEXT;
          state_next = S_MUL;
        end
      end
      S_SWAP1: begin
        cmd.wr_sel = pps_pkg::WR_K_IVAL;
        state_next = S_SWAP2;
      end
      S_SWAP2: begin
        cmd.wr_sel = pps_pkg::WR_I_BEST;
        cmd.i_inc  = 1'b1;
        state_next = status.row_next ? S_ROW_RD : S_OUT_RD;
      end
      S_OUT_RD: begin
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (out_take) begin
          if (status.e_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.e_inc  = 1'b1;
            state_next = S_OUT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_SHOW);
    end
  end

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open at once");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (in_take && in_last) |=> !in_ready)
    else $error("input still open after last point");

  a_set_done: assert property (@(posedge clk) disable iff (rst)
    (out_take && status.e_last) |=> (in_ready && !out_valid))
    else $error("not back to loading after final result");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 12;
  localparam int FB         = pps_pkg::FIELD_BITS;

  // how the coordinates of a random set are spread
  typedef enum int {
    SPREAD_FULL,
    SPREAD_TINY,
    SPREAD_EDGE
  } spread_t;

  typedef struct {
    logic [FB-1:0] x;
    logic [FB-1:0] y;
    logic          last;
    logic          dropped;
  } sorted_point_t;

  logic clk = 1'b0;
  logic rst;

  pps_in_if  pt_in_bus ();
  pps_out_if pt_out_bus ();

  polar_angle_point_sort_top #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .pt_in (pt_in_bus),
    .pt_out(pt_out_bus)
  );

  always #1 clk = ~clk;

  // idle and stall rates in percent
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fault_count;

  // predicted contents of the point memory
  logic [COORD_BITS-1:0] held_x [MAX_POINTS];
  logic [COORD_BITS-1:0] held_y [MAX_POINTS];
  int unsigned           held_count;
  bit                    held_overflow;

  sorted_point_t sorted_expect [$];

  // cross product of (pivot - cand) and (best - cand); positive: cand has smaller angle
  function automatic longint angle_cross(int unsigned cand, int unsigned best);
    longint ax, ay, bx, by;
    ax = longint'(held_x[0]) - longint'(held_x[cand]);
    ay = longint'(held_y[0]) - longint'(held_y[cand]);
    bx = longint'(held_x[best]) - longint'(held_x[cand]);
    by = longint'(held_y[best]) - longint'(held_y[cand]);
    return ax * by - bx * ay;
  endfunction

  function automatic longint dist_from_pivot(int unsigned slot);
    longint dx, dy;
    dx = longint'(held_x[0]) - longint'(held_x[slot]);
    dy = longint'(held_y[0]) - longint'(held_y[slot]);
    return dx * dx + dy * dy;
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [COORD_BITS-1:0] tx, ty;
    tx = held_x[a];
    ty = held_y[a];
    held_x[a] = held_x[b];
    held_y[a] = held_y[b];
    held_x[b] = tx;
    held_y[b] = ty;
  endfunction

  // pivot to slot 0, then selection sort of the rest by angle, nearer first on ties
  function automatic void order_by_angle(int unsigned n);
    int unsigned piv, best;
    longint      c;
    piv = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (held_y[i] < held_y[piv] || (held_y[i] == held_y[piv] && held_x[i] < held_x[piv]))
        piv = i;
    end
    swap_slots(0, piv);
    for (int unsigned i = 1; i + 1 < n; i++) begin
      best = i;
      for (int unsigned j = i + 1; j < n; j++) begin
        c = angle_cross(j, best);
        if (c > 0 || (c == 0 && dist_from_pivot(j) < dist_from_pivot(best)))
          best = j;
      end
      swap_slots(i, best);
    end
  endfunction

  // store one accepted point; on the last one, queue the ordered set
  function automatic void absorb_point(logic [FB-1:0] x, logic [FB-1:0] y, logic last);
    sorted_point_t sp;
    if (held_count < MAX_POINTS) begin
      held_x[held_count] = x[COORD_BITS-1:0];
      held_y[held_count] = y[COORD_BITS-1:0];
      held_count++;
    end else begin
      held_overflow = 1'b1;
    end
    if (last) begin
      order_by_angle(held_count);
      for (int unsigned i = 0; i < held_count; i++) begin
        sp.x       = FB'(held_x[i]);
        sp.y       = FB'(held_y[i]);
        sp.last    = (i + 1 == held_count);
        sp.dropped = held_overflow;
        sorted_expect.push_back(sp);
      end
      held_count    = 0;
      held_overflow = 1'b0;
    end
  endfunction

  // present one item, wait for it to be taken; valid stays high on return
  task automatic send_point(logic [FB-1:0] x, logic [FB-1:0] y, logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      pt_in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pt_in_bus.valid      <= 1'b1;
    pt_in_bus.point_x    <= x;
    pt_in_bus.point_y    <= y;
    pt_in_bus.last_point <= last;
    do @(posedge clk); while (!pt_in_bus.ready);
    absorb_point(x, y, last);
  endtask

  function automatic logic [FB-1:0] pick_coord(spread_t spread, logic [FB-1:0] base);
    logic [FB-1:0] v;
    case (spread)
      SPREAD_TINY: v = base + FB'($urandom_range(7));
      SPREAD_EDGE: begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = FB'(1);
          2: v = {FB{1'b1}} - FB'(1);
          default: v = {FB{1'b1}};
        endcase
      end
      default: v = FB'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_random_set(int unsigned n, spread_t spread);
    logic [FB-1:0] bx, by;
    bx = FB'($urandom_range((1 << FB) - 8));
    by = FB'($urandom_range((1 << FB) - 8));
    for (int unsigned k = 0; k < n; k++)
      send_point(pick_coord(spread, bx), pick_coord(spread, by), k + 1 == n);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // sets of one point at both corners
  task automatic test_single_point();
    send_point('0, '0, 1'b1);
    send_point({FB{1'b1}}, {FB{1'b1}}, 1'b1);
  endtask

  // several candidates share the least y, two of them identical
  task automatic test_pivot_ties();
    send_point(FB'(3000), FB'(5), 1'b0);
    send_point({FB{1'b1}}, '0, 1'b0);
    send_point(FB'(7), '0, 1'b0);
    send_point(FB'(7), '0, 1'b0);
    send_point(FB'(900), FB'(2), 1'b1);
  endtask

  // points on rays from the pivot, out of distance order, with a duplicate
  task automatic test_collinear();
    send_point(FB'(40), FB'(40), 1'b0);
    send_point(FB'(20), FB'(20), 1'b0);
    send_point(FB'(10), FB'(10), 1'b0);
    send_point(FB'(30), FB'(30), 1'b0);
    send_point(FB'(50), FB'(10), 1'b0);
    send_point(FB'(30), FB'(10), 1'b0);
    send_point(FB'(10), FB'(4000), 1'b0);
    send_point(FB'(20), FB'(20), 1'b1);
  endtask

  // corners and near-corners of the coordinate range
  task automatic test_extremes();
    send_point({FB{1'b1}}, '0, 1'b0);
    send_point('0, {FB{1'b1}}, 1'b0);
    send_point({FB{1'b1}}, {FB{1'b1}}, 1'b0);
    send_point(FB'(2048), FB'(2048), 1'b0);
    send_point('0, FB'(1), 1'b0);
    send_point(FB'(1), '0, 1'b0);
    send_point('0, '0, 1'b1);
  endtask

  // exactly a full memory, nothing dropped
  task automatic test_store_full();
    send_random_set(MAX_POINTS, SPREAD_FULL);
  endtask

  // points past capacity, the last one among them
  task automatic test_overflow();
    send_random_set(MAX_POINTS + 2, SPREAD_TINY);
  endtask

  // mostly small sets of random points
  task automatic test_random_sets(int unsigned points_total);
    int unsigned sent, n;
    sent = 0;
    while (sent < points_total) begin
      n = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      send_random_set(n, spread_t'($urandom_range(2)));
      sent += n;
    end
  endtask

  // result checker; also drives ready for the next cycle
  initial begin : result_check
    sorted_point_t want;
    pt_out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pt_out_bus.valid && pt_out_bus.ready) begin
        if (sorted_expect.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result item: x=%0d y=%0d last=%0b dropped=%0b",
                     pt_out_bus.out_x, pt_out_bus.out_y, pt_out_bus.out_last,
                     pt_out_bus.dropped_points);
        end else begin
          want = sorted_expect.pop_front();
          if (pt_out_bus.out_x !== want.x || pt_out_bus.out_y !== want.y ||
              pt_out_bus.out_last !== want.last ||
              pt_out_bus.dropped_points !== want.dropped) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch: want x=%0d y=%0d last=%0b drop=%0b, got %0d %0d %0b %0b",
                       want.x, want.y, want.last, want.dropped,
                       pt_out_bus.out_x, pt_out_bus.out_y, pt_out_bus.out_last,
                       pt_out_bus.dropped_points);
          end
        end
      end
      pt_out_bus.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run-away guard
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    fault_count   = 0;
    held_count    = 0;
    held_overflow = 1'b0;
    set_idling(0, 0);
    rst                  <= 1'b1;
    pt_in_bus.valid      <= 1'b0;
    pt_in_bus.point_x    <= '0;
    pt_in_bus.point_y    <= '0;
    pt_in_bus.last_point <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_single_point();
    test_pivot_ties();
    test_collinear();
    test_extremes();
    test_store_full();

    set_idling(59, 0);
    test_random_sets(40);
    set_idling(0, 59);
    test_random_sets(40);
    set_idling(36, 36);
    test_overflow();
    test_random_sets(40);
    set_idling(0, 0);
    test_random_sets(15);

    pt_in_bus.valid <= 1'b0;
    while (sorted_expect.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (fault_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
